[rtl/pkxd_pkg.sv]
// Shared constants, stream layouts and the fixed XOR table of the descrambler.
`default_nettype none
package pkxd_pkg;

  localparam int KEY_DEPTH       = 64;
  localparam int KIDX_W          = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int FIXED_TABLE_LEN = 23;
  localparam int FIDX_W          = $clog2(FIXED_TABLE_LEN);

  // Field widths of one input beat
  localparam int KEY_INDEX_W     = 6;
  localparam int BYTE_W          = 8;
  localparam int OFFSET_W        = 16;
  localparam int LEN_W           = 7;

  // Bit positions inside the input tdata
  localparam int KEY_INDEX_LSB   = 0;
  localparam int BYTE_IN_LSB     = KEY_INDEX_LSB + KEY_INDEX_W;
  localparam int FIRST_LSB       = BYTE_IN_LSB + BYTE_W;
  localparam int OFFSET_LSB      = FIRST_LSB + 1;
  localparam int IN_USED_W       = OFFSET_LSB + OFFSET_W;
  localparam int IN_TDATA_W      = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W     = BYTE_W;

  // Item kinds carried in tuser
  localparam logic OP_KEY_LOAD   = 1'b0;
  localparam logic OP_DATA       = 1'b1;

  function automatic logic [BYTE_W-1:0] fixed_tab(input logic [FIDX_W-1:0] idx);
    logic [BYTE_W-1:0] v;
    case (idx)
      5'd0:    v = 8'h40;
      5'd1:    v = 8'h21;
      5'd2:    v = 8'h28;
      5'd3:    v = 8'h38;
      5'd4:    v = 8'hA6;
      5'd5:    v = 8'h6E;
      5'd6:    v = 8'h43;
      5'd7:    v = 8'hA5;
      5'd8:    v = 8'h40;
      5'd9:    v = 8'h21;
      5'd10:   v = 8'h28;
      5'd11:   v = 8'h38;
      5'd12:   v = 8'hA6;
      5'd13:   v = 8'h43;
      5'd14:   v = 8'hA5;
      5'd15:   v = 8'h64;
      5'd16:   v = 8'h3E;
      5'd17:   v = 8'h65;
      5'd18:   v = 8'h24;
      5'd19:   v = 8'h20;
      5'd20:   v = 8'h46;
      5'd21:   v = 8'h6E;
      5'd22:   v = 8'h74;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/position_keyed_xor_descrambler.sv]
// Top level of the position-keyed XOR descrambler with its sequencer and key store.
//
// Usage:
//   s_axis carries one beat per item. tuser selects the kind: a key load
//   writes byte_in into key store entry key_index (ignored if beyond the
//   store); a data beat is XORed with the low byte of its position, the
//   fixed 23-entry table and, if key_length is nonzero, the key store.
//   first starts a buffer at start_offset; last is copied to m_axis_tlast.
//   cfg carries key_length; write it only while the block is idle.
// Sequencing:
//   A key load is written at acceptance and the port stays ready for the next beat.
//   A data beat within a buffer goes through accept, key store read
//   (registered read port), XOR into the output register.
//   The first beat of a buffer first reduces offset mod 23 and, when
//   key_length is nonzero, offset mod the key length clamped to the store depth:
//   one shared compare-and-subtract unit produces one remainder bit per cycle.
// Reset:
//   rst clears the position counters, key_length and the output valid.
//   Key store entries stay undefined until loaded.
// Stall:
//   The output register holds a result until m_axis_tready; the block still
//   accepts the next beat and stops only before writing another result.
`default_nettype none
module position_keyed_xor_descrambler (
  input  wire                                clk,
  input  wire                                rst,
  // cfg_data: key_length [6:0]
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [pkxd_pkg::LEN_W-1:0]          cfg_data,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // s_axis_tdata: key_index [5:0], byte_in [13:6], first [14],
  //               start_offset [30:15], zero [31]
  input  wire [pkxd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // s_axis_tuser: op [0]
  input  wire                                s_axis_tuser,
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // m_axis_tdata: byte_out [7:0]
  output logic [pkxd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);
  import pkxd_pkg::*;

  localparam int STEP_W = $clog2(OFFSET_W);
  localparam int KCMP_W = ((KIDX_W > LEN_W) ? KIDX_W : LEN_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_READ, S_EMIT} state_t;

  state_t                state;
  logic [LEN_W-1:0]      key_length;
  logic [BYTE_W-1:0]     pos_low;
  logic [FIDX_W-1:0]     fidx;
  logic [KIDX_W-1:0]     kidx;
  logic [BYTE_W-1:0]     byte_q;
  logic                  last_q;
  logic [OFFSET_W-1:0]   offset_q;
  logic [OFFSET_W-1:0]   dividend;
  logic [LEN_W-1:0]      rem;
  logic [STEP_W-1:0]     step;
  logic                  pass_key;
  logic [BYTE_W-1:0]     key_q;
  logic [BYTE_W-1:0]     key_store [KEY_DEPTH];

  // Unpacked input fields
  logic [KEY_INDEX_W-1:0] in_key_index;
  logic [BYTE_W-1:0]      in_byte;
  logic                   in_first;
  logic [OFFSET_W-1:0]    in_offset;
  logic                   in_fire;
  logic                   key_wr;

  assign in_key_index = s_axis_tdata[KEY_INDEX_LSB +: KEY_INDEX_W];
  assign in_byte      = s_axis_tdata[BYTE_IN_LSB +: BYTE_W];
  assign in_first     = s_axis_tdata[FIRST_LSB];
  assign in_offset    = s_axis_tdata[OFFSET_LSB +: OFFSET_W];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign key_wr        = in_fire && (s_axis_tuser == OP_KEY_LOAD)
                         && (32'(in_key_index) < KEY_DEPTH);

  // Key length in use, clamped to the store depth
  logic [LEN_W-1:0] len;
  assign len = (32'(key_length) > KEY_DEPTH) ? LEN_W'(KEY_DEPTH) : key_length;

  // Shared restoring remainder step: shift in one dividend bit, subtract if it fits
  logic [LEN_W-1:0] divisor;
  logic [LEN_W:0]   trial;
  logic [LEN_W-1:0] rem_next;
  assign divisor  = pass_key ? len : LEN_W'(FIXED_TABLE_LEN);
  assign trial    = {rem, dividend[OFFSET_W-1]};
  assign rem_next = (trial >= {1'b0, divisor}) ? LEN_W'(trial - {1'b0, divisor})
                                               : LEN_W'(trial);

  // XOR of one data byte and the wrapped successors of the indices
  logic [BYTE_W-1:0] x_byte;
  logic [FIDX_W-1:0] fidx_next;
  logic [KIDX_W-1:0] kidx_next;
  logic [KCMP_W-1:0] kidx_succ;
  logic              emit_ok;
  assign x_byte    = byte_q ^ pos_low ^ fixed_tab(fidx) ^ ((len != '0) ? key_q : '0);
  assign fidx_next = (32'(fidx) + 1 >= FIXED_TABLE_LEN) ? '0 : FIDX_W'(fidx + 1'b1);
  assign kidx_succ = KCMP_W'(kidx) + 1'b1;
  assign kidx_next = ((len == '0) || (kidx_succ >= KCMP_W'(len))) ? '0
                                                                   : KIDX_W'(kidx_succ);
  assign emit_ok   = !m_axis_tvalid || m_axis_tready;

  // Key store: one write port, registered read
  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_store[KIDX_W'(in_key_index)] <= in_byte;
    end
    if (state == S_READ) begin
      key_q <= key_store[kidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      key_length    <= '0;
      pos_low       <= '0;
      fidx          <= '0;
      kidx          <= '0;
      m_axis_tvalid <= 1'b0;
      step          <= '0;
      pass_key      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_length <= cfg_data;
      end
      // Raise valid on a new result, drop it once the beat is taken
      if ((state == S_EMIT) && emit_ok) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (s_axis_tuser == OP_DATA)) begin
            byte_q <= in_byte;
            last_q <= s_axis_tlast;
            if (in_first) begin
              // Start a buffer: take the position, reduce the offset
              pos_low  <= in_offset[BYTE_W-1:0];
              offset_q <= in_offset;
              dividend <= in_offset;
              rem      <= '0;
              step     <= '0;
              pass_key <= 1'b0;
              state    <= S_MOD;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_MOD: begin
          step <= step + 1'b1;
          if (step == STEP_W'(OFFSET_W - 1)) begin
            if (!pass_key) begin
              fidx <= FIDX_W'(rem_next);
              if (len == '0) begin
                kidx  <= '0;
                state <= S_READ;
              end else begin
                // Rerun the unit on the same offset against the key length
                pass_key <= 1'b1;
                dividend <= offset_q;
                rem      <= '0;
              end
            end else begin
              kidx  <= KIDX_W'(rem_next);
              state <= S_READ;
            end
          end else begin
            dividend <= {dividend[OFFSET_W-2:0], 1'b0};
            rem      <= rem_next;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          // Hold here while the previous result is still waiting
          if (emit_ok) begin
            m_axis_tdata  <= x_byte;
            m_axis_tlast  <= last_q;
            pos_low       <= pos_low + 1'b1;
            fidx          <= fidx_next;
            kidx          <= kidx_next;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pkxd_checker.sv]
// Port-level assertions for the descrambler and their bind to the top level.
`default_nettype none
module pkxd_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire                               s_axis_tuser,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [pkxd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire                               m_axis_tlast
);
  import pkxd_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // A key load never produces a result
  a_key_no_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_KEY_LOAD) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result after key load");

  // A data beat keeps the input closed while it is worked on
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_DATA) |=> !s_axis_tready)
    else $error("input ready during data beat");

endmodule

bind position_keyed_xor_descrambler pkxd_checker u_pkxd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[sim/position_keyed_xor_descrambler_test.sv]
// Stream testbench of the position-keyed XOR descrambler, with its own predictor.
`timescale 1ns / 1ps
module position_keyed_xor_descrambler_test;
  import pkxd_pkg::*;

  // One input beat before packing, and one descrambled byte as it should come out
  typedef struct packed {
    logic                   op;
    logic [KEY_INDEX_W-1:0] key_index;
    logic [BYTE_W-1:0]      byte_in;
    logic                   first;
    logic [OFFSET_W-1:0]    start_offset;
    logic                   last;
  } scramble_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              last_out;
  } plain_byte_t;

  // Fixed XOR table, entry 0 in the lowest byte
  localparam logic [FIXED_TABLE_LEN*8-1:0] FIXED_XOR_BYTES = {
    8'h74, 8'h6E, 8'h46, 8'h20, 8'h24, 8'h65, 8'h3E, 8'h64,
    8'hA5, 8'h43, 8'hA6, 8'h38, 8'h28, 8'h21, 8'h40, 8'hA5,
    8'h43, 8'h6E, 8'hA6, 8'h38, 8'h28, 8'h21, 8'h40
  };
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  position_keyed_xor_descrambler DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Beats waiting to be driven, and descrambled bytes waiting to come out
  scramble_beat_t pending_beats[$];
  plain_byte_t    expected_plain[$];
  scramble_beat_t beat_on_bus;
  logic           beat_taken = 1'b0;

  // Predictor state: key store image, position low byte, both table indices
  logic [BYTE_W-1:0] key_image [KEY_DEPTH];
  logic [BYTE_W-1:0] pos_low = '0;
  int                fixed_idx = 0;
  int                key_idx = 0;
  int                key_len = 0;

  // Key entries already loaded or queued for loading; never read one that is not
  logic              key_loaded [KEY_DEPTH];

  int mismatches    = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 47;
  int holds_asked   = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int run_left      = 0;

  function automatic scramble_beat_t mk_beat(input logic op, input int idx,
                                             input int data, input logic first,
                                             input int offset, input logic last);
    scramble_beat_t b;
    b.op           = op;
    b.key_index    = idx[KEY_INDEX_W-1:0];
    b.byte_in      = data[BYTE_W-1:0];
    b.first        = first;
    b.start_offset = offset[OFFSET_W-1:0];
    b.last         = last;
    return b;
  endfunction

  task automatic queue_beat(input scramble_beat_t b);
    if (b.op == OP_KEY_LOAD)
      key_loaded[b.key_index] = 1'b1;
    pending_beats.push_back(b);
  endtask

  // Advance the predictor by one accepted beat; a data beat yields one byte
  task automatic predict_descramble(input scramble_beat_t b);
    int          len;
    plain_byte_t r;
    len = (key_len > KEY_DEPTH) ? KEY_DEPTH : key_len;
    if (b.op == OP_KEY_LOAD) begin
      key_image[b.key_index] = b.byte_in;
      return;
    end
    if (b.first) begin
      pos_low   = b.start_offset[7:0];
      fixed_idx = int'(b.start_offset) % FIXED_TABLE_LEN;
      key_idx   = (len != 0) ? int'(b.start_offset) % len : 0;
    end
    r.byte_out = b.byte_in ^ pos_low ^ FIXED_XOR_BYTES[fixed_idx*8 +: 8];
    // After a shorter length is set mid-run the index may sit past it; use it as is
    if (len != 0)
      r.byte_out = r.byte_out ^ key_image[key_idx];
    r.last_out = b.last;
    expected_plain.push_back(r);
    pos_low   = pos_low + 8'd1;
    fixed_idx = (fixed_idx + 1 >= FIXED_TABLE_LEN) ? 0 : fixed_idx + 1;
    key_idx   = (len == 0 || key_idx + 1 >= len) ? 0 : key_idx + 1;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Sender: present a new beat once the current one is taken, or idle at random
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        beat_on_bus    = pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= beat_on_bus.op;
        s_axis_tlast  <= beat_on_bus.last;
        // Pack from the lowest bit up: key_index, byte_in, first, start_offset
        s_axis_tdata  <= IN_TDATA_W'({beat_on_bus.start_offset, beat_on_bus.first,
                                      beat_on_bus.byte_in, beat_on_bus.key_index});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Input side: feed every accepted beat to the predictor
  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        predict_descramble(beat_on_bus);
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output side: compare each result beat with the oldest expected byte
  always @(posedge clk) begin
    plain_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_plain.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", m_axis_tdata));
      end else begin
        want = expected_plain.pop_front();
        if (m_axis_tdata !== want.byte_out)
          report_mismatch($sformatf("byte_out %02h, want %02h", m_axis_tdata, want.byte_out));
        if (m_axis_tlast !== want.last_out)
          report_mismatch($sformatf("last_out %b, want %b", m_axis_tlast, want.last_out));
      end
    end
  end

  // Wait until every beat is taken and every byte has come out
  task automatic drain();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_plain.size() != 0)
      @(posedge clk);
  endtask

  // Load any key entry the new length reaches, drain, then write the register
  task automatic set_key_length(input int len);
    int k;
    for (k = 0; k < len && k < KEY_DEPTH; k++)
      if (!key_loaded[k])
        queue_beat(mk_beat(OP_KEY_LOAD, k, $urandom_range(255), 1'b0, 0, 1'b0));
    drain();
    // A key load leaves no result behind; give it time to retire
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_data  <= len[LEN_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly well-formed runs of data beats with key loads mixed in
  task automatic queue_traffic(input int count);
    scramble_beat_t b;
    int             n;
    for (n = 0; n < count; n++) begin
      b = mk_beat(OP_DATA, $urandom_range(63), $urandom_range(255), 1'b0,
                  $urandom_range(65535), 1'b0);
      if ($urandom_range(99) < 12) begin
        b.op    = OP_KEY_LOAD;
        b.first = 1'($urandom_range(1));
        b.last  = 1'($urandom_range(1));
      end else begin
        if (run_left == 0) begin
          // Rarely run on from the old counters instead of starting fresh
          b.first  = ($urandom_range(99) >= 5);
          run_left = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 24);
        end else if ($urandom_range(99) < 2) begin
          b.first = 1'b1;
        end
        run_left--;
        b.last = (run_left == 0);
        if ($urandom_range(99) < 3)
          b.last = !b.last;
      end
      queue_beat(b);
    end
  endtask

  initial begin
    int lengths [9] = '{1, 64, 127, 23, 0, 7, 40, 64, 3};
    int p;
    for (p = 0; p < KEY_DEPTH; p++) begin
      key_image[p]  = '0;
      key_loaded[p] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats, key length still zero from reset
    // Data before any buffer start runs on from the reset counters
    queue_beat(mk_beat(OP_DATA, 0, 'hA5, 1'b0, 'h1234, 1'b0));
    queue_beat(mk_beat(OP_DATA, 63, 'h00, 1'b0, 0, 1'b1));
    // Key loads ignore first, last and offset
    queue_beat(mk_beat(OP_KEY_LOAD, 0, 'hFF, 1'b1, 'hFFFF, 1'b1));
    queue_beat(mk_beat(OP_KEY_LOAD, 63, 'h00, 1'b0, 0, 1'b0));
    queue_beat(mk_beat(OP_KEY_LOAD, 31, 'h5A, 1'b1, 0, 1'b0));
    // Top offset; the position low byte wraps on the next beat
    queue_beat(mk_beat(OP_DATA, 0, 'hFF, 1'b1, 'hFFFF, 1'b0));
    queue_beat(mk_beat(OP_DATA, 0, 'h00, 1'b0, 0, 1'b0));
    queue_beat(mk_beat(OP_DATA, 0, 'hFF, 1'b0, 0, 1'b1));
    // Fixed table wraps from its last entry to its first
    queue_beat(mk_beat(OP_DATA, 0, 'h3C, 1'b1, 21, 1'b0));
    queue_beat(mk_beat(OP_DATA, 0, 'hC3, 1'b0, 0, 1'b0));
    queue_beat(mk_beat(OP_DATA, 0, 'h00, 1'b0, 0, 1'b1));
    // One-beat buffers, first and last together
    queue_beat(mk_beat(OP_DATA, 0, 'h81, 1'b1, 22, 1'b1));
    queue_beat(mk_beat(OP_DATA, 0, 'h7E, 1'b1, 0, 1'b1));
    queue_beat(mk_beat(OP_DATA, 0, 'hFF, 1'b1, 23, 1'b1));
    // Restart without a last in between
    queue_beat(mk_beat(OP_DATA, 0, 'h11, 1'b1, 256, 1'b0));
    queue_beat(mk_beat(OP_DATA, 0, 'h22, 1'b1, 1000, 1'b1));

    // Random phases; a phase may end inside a run, so the length changes mid-buffer
    for (p = 0; p < 9; p++) begin
      send_idle_pct = (p < 3) ? 37 : (p < 6) ? 47 : 0;
      recv_idle_pct = (p < 3) ? 47 : (p < 6) ? 37 : 0;
      set_key_length(lengths[p]);
      queue_traffic(140);
      // Hold the output off while the sender keeps offering, so the block fills
      if (p == 2 || p == 7)
        holds_asked++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS position_keyed_xor_descrambler");
    else
      $display("FAIL position_keyed_xor_descrambler");
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("FAIL position_keyed_xor_descrambler");
    $finish;
  end

endmodule

[sim.f]
rtl/pkxd_pkg.sv
rtl/position_keyed_xor_descrambler.sv
rtl/pkxd_checker.sv
sim/position_keyed_xor_descrambler_test.sv
